@@ hdl/hpsa_pkg.sv @@
// ---------------------------------------------------------------------------
// hpsa_pkg: shared types and constants of the hall period speed averager
// Transaction payloads, queue command, codes and the back-end state type.
// ---------------------------------------------------------------------------
`default_nettype none

package hpsa_pkg;

	localparam int DATA_W   = 32;
	localparam int SPEED_W  = 16;
	localparam int CFG_IDX_W = 8;
	localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;

	// operation codes
	localparam logic OP_CLEAR = 1'b0;
	localparam logic OP_EDGE  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIMER_PERIOD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_NUM    = 8'd1;

	typedef struct packed {
		logic              operation;
		logic [DATA_W-1:0] timer_capture;
	} hall_item_t;

	typedef struct packed {
		logic [DATA_W-1:0]  period_delta;
		logic [SPEED_W-1:0] instant_speed;
		logic [SPEED_W-1:0] average_speed;
	} speed_item_t;

	// classified command passed from front end to back end
	typedef struct packed {
		logic              operation;
		logic [DATA_W-1:0] delta;
	} hpsa_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} hpsa_q_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_SUM,
		BK_OUT
	} hpsa_back_state_t;

endpackage

`default_nettype wire

@@ hdl/hpsa_ram.sv @@
// ---------------------------------------------------------------------------
// hpsa_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module hpsa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/hpsa_front.sv @@
// ---------------------------------------------------------------------------
// hpsa_front: input transaction acceptance and period extraction
// Forms the wrapped capture delta and pushes a command into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module hpsa_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           hall_valid,
	output logic                                hall_stall,
	input  wire hpsa_pkg::hall_item_t           hall_item,
	input  wire logic [hpsa_pkg::DATA_W-1:0]    timer_period,
	input  wire hpsa_pkg::hpsa_q_status_t       q_status,
	output logic                                push,
	output hpsa_pkg::hpsa_cmd_t                 push_cmd
);

	import hpsa_pkg::*;

	logic [DATA_W-1:0] last_capture_q;
	logic [DATA_W-1:0] delta;

	assign hall_stall = q_status.full;
	assign push       = hall_valid && !q_status.full;

	// equal capture wraps to one full timer period
	always_comb begin
		if (hall_item.timer_capture <= last_capture_q) begin
			delta = timer_period - (last_capture_q - hall_item.timer_capture);
		end else begin
			delta = hall_item.timer_capture - last_capture_q;
		end
	end

	assign push_cmd.operation = hall_item.operation;
	assign push_cmd.delta     = (hall_item.operation == OP_EDGE) ? delta : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_capture_q <= '0;
		end else if (push && hall_item.operation == OP_EDGE) begin
			last_capture_q <= hall_item.timer_capture;
		end
	end

endmodule

`default_nettype wire

@@ hdl/hpsa_queue.sv @@
// ---------------------------------------------------------------------------
// hpsa_queue: two-entry command queue
// Decouples the front end from the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module hpsa_queue (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	input  wire hpsa_pkg::hpsa_cmd_t      push_cmd,
	input  wire logic                     pop,
	output hpsa_pkg::hpsa_cmd_t           pop_cmd,
	output hpsa_pkg::hpsa_q_status_t      q_status
);

	import hpsa_pkg::*;

	hpsa_cmd_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign q_status.full  = (count_q == 2'd2);
	assign q_status.empty = (count_q == 2'd0);
	assign do_push = push && !q_status.full;
	assign do_pop  = pop && !q_status.empty;
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hdl/hpsa_back.sv @@
// ---------------------------------------------------------------------------
// hpsa_back: speed divide, moving-average window and result register
// Restoring divide one quotient bit per cycle, then window update.
// ---------------------------------------------------------------------------
`default_nettype none

module hpsa_back #(
	parameter int WINDOW_DEPTH = 8,
	parameter int AVG_SHIFT    = 3
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [hpsa_pkg::DATA_W-1:0] speed_numerator,
	input  wire hpsa_pkg::hpsa_q_status_t    q_status,
	input  wire hpsa_pkg::hpsa_cmd_t         pop_cmd,
	output logic                             pop,
	output logic                             speed_valid,
	input  wire logic                        speed_stall,
	output hpsa_pkg::speed_item_t            speed_item
);

	import hpsa_pkg::*;

	localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int SUM_W  = SPEED_W + SLOT_W;
	localparam int CNT_W  = $clog2(DATA_W);

	hpsa_back_state_t state_q, state_d;

	logic [DATA_W-1:0]       delta_q;
	logic [DATA_W-1:0]       rem_q;
	logic [DATA_W-1:0]       quo_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [WINDOW_DEPTH-1:0] valid_q;
	logic [SUM_W-1:0]        sum_q;
	speed_item_t             res_q;
	logic                    out_valid_q;
	speed_item_t             out_q;

	logic                    ram_re;
	logic                    ram_we;
	logic                    out_load;
	logic [SPEED_W-1:0]      ram_rdata;
	logic [SPEED_W-1:0]      old_speed;
	logic [SPEED_W-1:0]      new_speed;
	logic [SUM_W-1:0]        new_sum;
	logic [SUM_W-1:0]        avg_full;
	logic [SPEED_W-1:0]      avg_sat;
	logic [SLOT_W-1:0]       slot_next;
	logic [DATA_W:0]         trial;
	logic                    trial_ge;
	logic [DATA_W-1:0]       rem_next;

	hpsa_ram #(
		.WIDTH (SPEED_W),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (new_speed),
		.re    (ram_re),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	// divider step
	assign trial    = {rem_q, quo_q[DATA_W-1]};
	assign trial_ge = (trial >= {1'b0, delta_q});
	assign rem_next = trial_ge ? DATA_W'(trial - {1'b0, delta_q}) : trial[DATA_W-1:0];

	// window update
	assign new_speed = ((delta_q == '0) || (quo_q[DATA_W-1:SPEED_W] != '0)) ?
		SPEED_MAX : quo_q[SPEED_W-1:0];
	assign old_speed = valid_q[slot_q] ? ram_rdata : '0;
	assign new_sum   = sum_q - SUM_W'(old_speed) + SUM_W'(new_speed);
	assign avg_full  = new_sum >> AVG_SHIFT;
	assign avg_sat   = (avg_full > SUM_W'(SPEED_MAX)) ? SPEED_MAX : avg_full[SPEED_W-1:0];
	assign slot_next = (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_status.empty) begin
					state_d = (pop_cmd.operation == OP_EDGE) ? BK_DIV : BK_OUT;
				end
			end
			BK_DIV: begin
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					state_d = BK_SUM;
				end
			end
			BK_SUM: begin
				state_d = BK_OUT;
			end
			BK_OUT: begin
				if (!out_valid_q || !speed_stall) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		ram_re   = 1'b0;
		ram_we   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop    = !q_status.empty;
				ram_re = !q_status.empty;
			end
			BK_DIV: begin
			end
			BK_SUM: begin
				ram_we = 1'b1;
			end
			BK_OUT: begin
				out_load = !out_valid_q || !speed_stall;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			slot_q      <= '0;
			valid_q     <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				cnt_q <= '0;
				if (pop_cmd.operation == OP_CLEAR) begin
					slot_q  <= '0;
					valid_q <= '0;
					sum_q   <= '0;
				end
			end else if (state_q == BK_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (ram_we) begin
				valid_q[slot_q] <= 1'b1;
				slot_q          <= slot_next;
				sum_q           <= new_sum;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!speed_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			delta_q <= pop_cmd.delta;
			rem_q   <= '0;
			quo_q   <= speed_numerator;
			res_q   <= '0;
		end else if (state_q == BK_DIV) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DATA_W-2:0], trial_ge};
		end
		if (ram_we) begin
			res_q.period_delta  <= delta_q;
			res_q.instant_speed <= new_speed;
			res_q.average_speed <= avg_sat;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign speed_valid = out_valid_q;
	assign speed_item  = out_q;

endmodule

`default_nettype wire

@@ hdl/hall_period_speed_averager.sv @@
// ---------------------------------------------------------------------------
// hall_period_speed_averager: hall edge period, speed and moving average
//
// Input channel (hall_valid / hall_stall / hall_item): one transaction per
// hall edge carrying a timer capture, or a clear that empties the window.
// Output channel (speed_valid / speed_stall / speed_item): exactly one
// result transaction per input transaction, in order.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
// the timer period, index 1 the speed numerator; other indexes are dropped.
// cfg_ready is always high; write only while the block is idle.
// An edge runs through the queue, the 32-step restoring divider, the window
// update and the output register of the back end; a clear empties the window
// and goes straight to the output register. The back end pops only when idle.
// A two-entry queue sits between front and back end, so the front keeps
// accepting while a result waits on a stalled receiver; hall_stall rises
// only once the queue is full.
// Reset clears the last capture, the window valid bits, slot and sum, and
// loads the registers with their defaults; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module hall_period_speed_averager #(
	parameter int WINDOW_DEPTH = 8,
	parameter int AVG_SHIFT    = 3
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           hall_valid,
	output logic                                hall_stall,
	input  wire hpsa_pkg::hall_item_t           hall_item,
	output logic                                speed_valid,
	input  wire logic                           speed_stall,
	output hpsa_pkg::speed_item_t               speed_item,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [hpsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [hpsa_pkg::DATA_W-1:0]    cfg_data
);

	import hpsa_pkg::*;

	logic [DATA_W-1:0] timer_period_q;
	logic [DATA_W-1:0] speed_numerator_q;
	logic              push;
	logic              pop;
	hpsa_cmd_t         push_cmd;
	hpsa_cmd_t         pop_cmd;
	hpsa_q_status_t    q_status;

	// configuration registers; writes are only expected while idle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_period_q    <= 32'hFFFF_FFFF;
			speed_numerator_q <= 32'd1000000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TIMER_PERIOD: timer_period_q    <= cfg_data;
				REG_SPEED_NUM:    speed_numerator_q <= cfg_data;
				default: begin
					// drop writes to unknown indexes
				end
			endcase
		end
	end

	// front end: accept, take the wrapped period, classify
	hpsa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.hall_valid   (hall_valid),
		.hall_stall   (hall_stall),
		.hall_item    (hall_item),
		.timer_period (timer_period_q),
		.q_status     (q_status),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	// hold classified commands until the back end is free
	hpsa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_status (q_status)
	);

	// back end: divide, advance the window, register the result
	hpsa_back #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.AVG_SHIFT    (AVG_SHIFT)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.speed_numerator (speed_numerator_q),
		.q_status        (q_status),
		.pop_cmd         (pop_cmd),
		.pop             (pop),
		.speed_valid     (speed_valid),
		.speed_stall     (speed_stall),
		.speed_item      (speed_item)
	);

endmodule

`default_nettype wire

@@ test/hpsa_speed_checker.sv @@
// ---------------------------------------------------------------------------
// hpsa_speed_checker: scoreboard for the hall period speed averager
// Watches the hall, speed and register channels. It mirrors the register
// file and the averaging window, predicts one speed transaction per
// accepted hall transaction and compares the results in order.
// ---------------------------------------------------------------------------

module hpsa_speed_checker #(
	parameter int WINDOW_DEPTH = 8,
	parameter int AVG_SHIFT    = 3
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           hall_valid,
	input  wire logic                           hall_stall,
	input  wire hpsa_pkg::hall_item_t           hall_item,
	input  wire logic                           speed_valid,
	input  wire logic                           speed_stall,
	input  wire hpsa_pkg::speed_item_t          speed_item,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [hpsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [hpsa_pkg::DATA_W-1:0]    cfg_data,
	output int                                  mismatch_count,
	output int                                  speeds_pending,
	output int                                  speeds_checked
);

	import hpsa_pkg::*;

	localparam int PRINT_CAP = 200;

	logic [DATA_W-1:0]  period_reg;
	logic [DATA_W-1:0]  numerator_reg;
	logic [DATA_W-1:0]  prev_capture;
	logic [SPEED_W-1:0] window_q [WINDOW_DEPTH];
	int unsigned        slot_q;
	logic [31:0]        sum_q;
	speed_item_t        expected_speeds [$];
	speed_item_t        want;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] mismatch, %s: got %0h, expected %0h", $time, what, got, exp_val);
		mismatch_count++;
	endtask

	// Advance the window model by one hall transaction and return its result.
	function automatic speed_item_t predict_speed(input hall_item_t it);
		speed_item_t        res;
		logic [DATA_W-1:0]  delta;
		logic [DATA_W-1:0]  quot;
		logic [SPEED_W-1:0] spd;
		logic [31:0]        avg;
		res = '0;
		if (it.operation == OP_CLEAR) begin
			for (int i = 0; i < WINDOW_DEPTH; i++)
				window_q[i] = '0;
			slot_q = 0;
			sum_q  = '0;
			return res;
		end
		// equal or lower capture: the timer wrapped at the period
		if (it.timer_capture <= prev_capture)
			delta = period_reg - (prev_capture - it.timer_capture);
		else
			delta = it.timer_capture - prev_capture;
		prev_capture = it.timer_capture;
		if (delta == '0) begin
			spd = SPEED_MAX;
		end else begin
			quot = numerator_reg / delta;
			spd  = (quot > 32'(SPEED_MAX)) ? SPEED_MAX : quot[SPEED_W-1:0];
		end
		sum_q = sum_q - 32'(window_q[slot_q]) + 32'(spd);
		window_q[slot_q] = spd;
		slot_q = (slot_q == WINDOW_DEPTH - 1) ? 0 : slot_q + 1;
		avg = sum_q >> AVG_SHIFT;
		res.period_delta  = delta;
		res.instant_speed = spd;
		res.average_speed = (avg > 32'(SPEED_MAX)) ? SPEED_MAX : avg[SPEED_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_reg    = 32'hFFFF_FFFF;
			numerator_reg = 32'd1_000_000;
			prev_capture  = '0;
			for (int i = 0; i < WINDOW_DEPTH; i++)
				window_q[i] = '0;
			slot_q = 0;
			sum_q  = '0;
			expected_speeds.delete();
			mismatch_count = 0;
			speeds_pending = 0;
			speeds_checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_TIMER_PERIOD)
					period_reg = cfg_data;
				else if (cfg_index == REG_SPEED_NUM)
					numerator_reg = cfg_data;
			end
			if (hall_valid && !hall_stall)
				expected_speeds.push_back(predict_speed(hall_item));
			if (speed_valid && !speed_stall) begin
				if (expected_speeds.size() == 0) begin
					report_mismatch("speed transaction with nothing expected",
						speed_item.period_delta, '0);
				end else begin
					want = expected_speeds.pop_front();
					if (speed_item.period_delta !== want.period_delta)
						report_mismatch("period_delta", speed_item.period_delta,
							want.period_delta);
					if (speed_item.instant_speed !== want.instant_speed)
						report_mismatch("instant_speed", 32'(speed_item.instant_speed),
							32'(want.instant_speed));
					if (speed_item.average_speed !== want.average_speed)
						report_mismatch("average_speed", 32'(speed_item.average_speed),
							32'(want.average_speed));
					speeds_checked++;
				end
			end
			speeds_pending = expected_speeds.size();
		end
	end

endmodule

@@ test/tb_hall_period_speed_averager.sv @@
// ---------------------------------------------------------------------------
// tb_hall_period_speed_averager: stimulus and verdict for the speed averager
// Drives hall edges and window clears through a directed opening and six
// randomized phases, each under its own timer period and speed numerator,
// with sender and receiver idling and long receiver hold-offs. A separate
// checker predicts and compares every speed transaction.
// ---------------------------------------------------------------------------

module tb_hall_period_speed_averager;

	import hpsa_pkg::*;

	localparam int WINDOW_DEPTH   = 8;
	localparam int AVG_SHIFT      = 3;
	localparam int PHASE_COUNT    = 6;
	localparam int PHASE_ITEMS    = 265;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 50;
	localparam int WATCHDOG_LIMIT = 5000;

	// register indexes that map to nothing, the block must drop them
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hFF;

	logic                 clk;
	logic                 arst_n;
	logic                 hall_valid;
	logic                 hall_stall;
	hall_item_t           hall_item;
	logic                 speed_valid;
	logic                 speed_stall = 1'b0;
	speed_item_t          speed_item;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;

	int mismatch_count;
	int speeds_pending;
	int speeds_checked;

	// stimulus bookkeeping
	logic [DATA_W-1:0] gen_last;
	logic [DATA_W-1:0] cur_period;
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;
	int                hold_request  = 0;
	int                hall_sent     = 0;
	int                clears_sent   = 0;
	int                settings_used = 0;
	int                quiet_cycles  = 0;

	hall_period_speed_averager #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.AVG_SHIFT   (AVG_SHIFT)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.hall_valid (hall_valid),
		.hall_stall (hall_stall),
		.hall_item  (hall_item),
		.speed_valid(speed_valid),
		.speed_stall(speed_stall),
		.speed_item (speed_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	hpsa_speed_checker #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.AVG_SHIFT   (AVG_SHIFT)
	) chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.hall_valid    (hall_valid),
		.hall_stall    (hall_stall),
		.hall_item     (hall_item),
		.speed_valid   (speed_valid),
		.speed_stall   (speed_stall),
		.speed_item    (speed_item),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatch_count(mismatch_count),
		.speeds_pending(speeds_pending),
		.speeds_checked(speeds_checked)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Receiver: stall at random each falling edge, or hold stall high for a
	// long stretch when the stimulus asks for one. Count the stretch here.
	int stall_hold_left = 0;
	always @(negedge clk) begin
		if (hold_request > 0) begin
			stall_hold_left = hold_request;
			hold_request = 0;
		end
		if (stall_hold_left > 0) begin
			speed_stall <= 1'b1;
			stall_hold_left--;
		end else begin
			speed_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Watchdog: end the run once no transaction of any channel has moved for
	// too long. Sample at the rising edge, where acceptance happens.
	always @(posedge clk) begin
		if (!arst_n || (hall_valid && !hall_stall) || (speed_valid && !speed_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
				quiet_cycles, speeds_pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Offer one hall transaction from a falling edge and hold it until
	// accepted; return on the falling edge after acceptance.
	task automatic send_hall(input hall_item_t it);
		hall_valid <= 1'b1;
		hall_item  <= it;
		@(posedge clk);
		while (hall_stall)
			@(posedge clk);
		if (it.operation == OP_EDGE)
			gen_last = it.timer_capture;
		else
			clears_sent++;
		hall_sent++;
		@(negedge clk);
	endtask

	task automatic send_edge(input logic [DATA_W-1:0] cap);
		send_hall('{operation: OP_EDGE, timer_capture: cap});
	endtask

	task automatic send_clear(input logic [DATA_W-1:0] cap);
		send_hall('{operation: OP_CLEAR, timer_capture: cap});
	endtask

	// Drop valid and wait until every expected speed result has arrived.
	task automatic settle();
		hall_valid <= 1'b0;
		do
			@(negedge clk);
		while (speeds_pending != 0);
	endtask

	// One register write; leave an extra falling edge so that back-to-back
	// writes never lower and raise cfg_valid in the same step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_setting(input logic [DATA_W-1:0] period, input logic [DATA_W-1:0] num);
		settle();
		write_reg(REG_TIMER_PERIOD, period);
		write_reg(REG_SPEED_NUM, num);
		cur_period = period;
		settings_used++;
	endtask

	// Mostly plausible capture streams: forward strides of widely spread
	// length, wraps inside the timer period, repeats; plus noise and clears.
	function automatic hall_item_t next_hall_item();
		hall_item_t  it;
		int unsigned pick;
		logic [63:0] wide;
		it.operation     = OP_EDGE;
		it.timer_capture = gen_last;
		pick = $urandom_range(99);
		// picks 5 to 9 keep the capture equal to the last one
		if (pick < 5) begin
			it.operation     = OP_CLEAR;
			it.timer_capture = $urandom;
		end else if (pick >= 10 && pick < 18) begin
			it.timer_capture = $urandom;
		end else if (pick >= 18 && pick < 26) begin
			wide = ({32'd0, gen_last} + 64'($urandom_range(cur_period, 1))) %
				{32'd0, cur_period};
			it.timer_capture = wide[DATA_W-1:0];
		end else if (pick >= 26 && pick < 34) begin
			it.timer_capture = gen_last + $urandom_range(3, 1);
		end else if (pick >= 34) begin
			it.timer_capture = gen_last + ($urandom >> $urandom_range(31, 4)) + 1;
		end
		return it;
	endfunction

	initial begin
		arst_n     = 1'b0;
		hall_valid = 1'b0;
		hall_item  = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		gen_last   = '0;
		cur_period = 32'hFFFF_FFFF;

		// Hold reset, then release it on a falling edge.
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed opening under the reset register values.
		send_edge(32'h0000_0000);        // equal to reset capture: one full period
		send_edge(32'd1000);             // plain forward step
		send_edge(32'd1000);             // equal capture again
		send_edge(32'd1001);             // one-count period: speed saturates
		send_edge(32'hFFFF_FFFF);        // largest capture
		send_edge(32'h0000_0000);        // wrap landing on a zero period
		send_clear(32'hFFFF_FFFF);       // clear keeps the last capture
		send_edge(32'd20);
		// Fill the window with saturated speeds and wrap the slot.
		for (int i = 0; i < 9; i++)
			send_edge(gen_last + 1);
		send_clear(32'h0000_0000);

		// Smallest timer period, largest numerator.
		apply_setting(32'd1, 32'hFFFF_FFFF);
		send_edge(gen_last - 5);         // capture below last: wrapped delta
		send_edge(gen_last);             // equal: delta equals the period
		send_edge(32'h8000_0000);

		// Smallest numerator, then writes to unmapped indexes that must be dropped.
		settle();
		write_reg(REG_SPEED_NUM, 32'd1);
		send_edge(gen_last + 2);         // quotient rounds down to zero
		settle();
		write_reg(REG_UNMAPPED_LO, 32'hFFFF_FFFF);
		write_reg(REG_UNMAPPED_HI, 32'hFFFF_FFFF);
		send_edge(gen_last + 1);         // speed 1 only if the numerator survived

		// Randomized phases: each under its own setting and idling mix.
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF);
				1: apply_setting(32'd1, 32'd1);
				2: apply_setting($urandom, $urandom);
				3: apply_setting(32'd1000, 32'd1_000_000);
				4: apply_setting(32'hFFFF_FFFF, 32'd1_000_000);
				default: apply_setting($urandom_range(32'd65536, 32'd2), $urandom);
			endcase
			if (ph < 2) begin
				send_idle_pct = 12;
				recv_idle_pct = 86;
			end else if (ph < 4) begin
				send_idle_pct = 86;
				recv_idle_pct = 12;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Hold off the receiver while the sender keeps offering, so
				// the block fills up and stalls its input.
				if ((ph == 0 || ph == 4) && n == 20)
					hold_request = HOLD_CYCLES;
				// Pause the sender until every result is back.
				if (ph == 2 && n == 100)
					settle();
				send_hall(next_hall_item());
				if ($urandom_range(99) < send_idle_pct) begin
					hall_valid <= 1'b0;
					do
						@(negedge clk);
					while ($urandom_range(99) < send_idle_pct);
				end
			end
		end

		// Drain: wait for every result, then watch for strays a little longer.
		settle();
		recv_idle_pct = 0;
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Run covered %0d hall transactions (%0d clears) under %0d register settings.",
			hall_sent, clears_sent, settings_used);
		$display("Compared %0d speed results through idling on both sides and receiver hold-offs.",
			speeds_checked);
		if (mismatch_count == 0 && speeds_pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			if (speeds_pending != 0)
				$display("%0d expected speed results never arrived", speeds_pending);
			$display("%0d mismatches found", mismatch_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
